// ===== hdl/srvp_pkg.sv =====
// Shared constants and types for the square-root velocity profile block.
// No dependencies; imported by sqrt_ramp_velocity_profile, speed_profile_checker and testbench.
`default_nettype none

package srvp_pkg;

    // Fixed field widths of the configuration registers
    localparam int DIST_W  = 20;  // accel_dist, decel_dist, segment_length
    localparam int GAIN_W  = 8;   // decel_gain, units of 1/256
    localparam int STOP_W  = 10;  // stop_threshold
    localparam int ROOT_W  = 32;  // square root result is capped to this width
    localparam int APB_W   = 32;  // APB data width
    localparam int ADDR_W  = 5;   // seven registers at byte addresses 4*i

    // Register map, word index = paddr[ADDR_W-1:2]
    typedef enum logic [2:0] {
        REG_MAX_SPEED  = 3'd0,
        REG_MIN_SPEED  = 3'd1,
        REG_ACCEL_DIST = 3'd2,
        REG_DECEL_DIST = 3'd3,
        REG_DECEL_GAIN = 3'd4,
        REG_SEG_LEN    = 3'd5,
        REG_STOP_THR   = 3'd6
    } reg_idx_t;

    // Reset values
    localparam int RST_MAX_SPEED  = 9000;
    localparam int RST_MIN_SPEED  = 700;
    localparam int RST_ACCEL_DIST = 1000;
    localparam int RST_DECEL_DIST = 1000;
    localparam int RST_DECEL_GAIN = 205;
    localparam int RST_SEG_LEN    = 2720;
    localparam int RST_STOP_THR   = 20;

endpackage

`default_nettype wire

// ===== hdl/sqrt_ramp_velocity_profile.sv =====
// Square-root velocity profile for one axis: bit-serial multiply, divide and
// square root on a shared work shift register. Depends on srvp_pkg.
`default_nettype none

// Channel    | Dir | Handshake                    | Content
// -----------+-----+------------------------------+-------------------------------------
// s_axis     | in  | s_axis_tvalid/s_axis_tready  | target_pos, robot_pos
// m_axis     | out | m_axis_tvalid/m_axis_tready  | speed_cmd, arrived
// APB        | in  | psel/penable/pwrite, pready  | seven profile registers, 4*i
//
// After accept an item passes ST_ABS and ST_PREP, then XW multiply steps,
// NUM_W restoring divide steps and RW square-root steps, one bit (root: one
// bit per two input bits) per cycle through the work shift register, and
// then ST_SCALE and ST_FIN; a zero divisor skips the three loops. One item
// is in flight at a time; s_axis_tready is high only while idle. The
// finished result sits in the output register, so a new item can be
// taken while it waits; a stall on m_axis holds the core in its final
// state. Reset clears control state and loads register defaults; a write
// to any mapped register clears the arrived latch.

module sqrt_ramp_velocity_profile #(
    parameter int POS_WIDTH   = 20,
    parameter int SPEED_WIDTH = 14
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    // tdata: target_pos [PW-1:0], robot_pos [2PW-1:PW], zero fill
    input  wire logic [((2*POS_WIDTH+7)/8)*8-1:0]            s_axis_tdata,
    input  wire logic                                        s_axis_tvalid,
    output logic                                             s_axis_tready,
    // tdata: speed_cmd [SW:0], arrived [SW+1], zero fill
    output logic [((SPEED_WIDTH+2+7)/8)*8-1:0]               m_axis_tdata,
    output logic                                             m_axis_tvalid,
    input  wire logic                                        m_axis_tready,
    input  wire logic                                        psel,
    input  wire logic                                        penable,
    input  wire logic                                        pwrite,
    input  wire logic [srvp_pkg::ADDR_W-1:0]                 paddr,
    input  wire logic [srvp_pkg::APB_W-1:0]                  pwdata,
    output logic [srvp_pkg::APB_W-1:0]                       prdata,
    output logic                                             pready
);

    import srvp_pkg::*;

    localparam int PW    = POS_WIDTH;
    localparam int SW    = SPEED_WIDTH;
    localparam int OUT_W = ((SW+2+7)/8)*8;
    localparam int EW    = PW + 1;                       // error width
    localparam int XW    = (EW > DIST_W) ? EW : DIST_W;  // ramp distance width
    localparam int MW    = 2*SW;                         // max_speed squared
    localparam int NUM_W = MW + XW;                      // numerator / quotient
    localparam int RW    = (NUM_W + 1) / 2;              // root width
    localparam int QE    = 2*RW;                         // quotient padded to even
    localparam int RWX   = (RW > ROOT_W) ? RW : ROOT_W;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ABS   = 8'b0000_0010,
        ST_PREP  = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_DIV   = 8'b0001_0000,
        ST_SQRT  = 8'b0010_0000,
        ST_SCALE = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    // control state
    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic               arrived_reg, arrived_next;

    // configuration
    logic [SW-1:0]      max_speed_reg,  min_speed_reg;
    logic [DIST_W-1:0]  accel_dist_reg, decel_dist_reg, seg_len_reg;
    logic [GAIN_W-1:0]  decel_gain_reg;
    logic [STOP_W-1:0]  stop_thr_reg;

    // datapath
    logic [EW-1:0]      err_reg,   err_next;
    logic               neg_reg,   neg_next;
    logic               zero_reg,  zero_next;
    logic [EW-1:0]      aerr_reg,  aerr_next;
    logic [MW-1:0]      m2_reg,    m2_next;
    logic               accel_reg, accel_next;
    logic               stop_reg,  stop_next;
    logic               cap_reg,   cap_next;
    logic [DIST_W-1:0]  den_reg,   den_next;
    logic [QE-1:0]      work_reg,  work_next;
    logic [DIST_W-1:0]  drem_reg,  drem_next;
    logic [RW-1:0]      root_reg,  root_next;
    logic [RW+1:0]      srem_reg,  srem_next;
    logic [SW-1:0]      mag_reg,   mag_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // combinational helpers
    logic               s_acc;
    logic               cfg_we;
    reg_idx_t           cfg_idx;
    logic [PW-1:0]      tgt_in, pos_in;
    logic [XW-1:0]      aerr_x, seg_x, dist_a, dist_b, ramp_x;
    logic               accel_now;
    logic [MW:0]        mul_sum;
    logic [DIST_W:0]    div_t;
    logic               div_ge;
    logic [RW+3:0]      sq_t, sq_trial;
    logic               sq_ge;
    logic [RWX-1:0]     root_x;
    logic [ROOT_W-1:0]  s32;
    logic [ROOT_W:0]    acc_sum;
    logic [SW-1:0]      acc_mag, dec_mag;
    logic [ROOT_W+GAIN_W-1:0] dec_prod;
    logic [ROOT_W-1:0]  dec_shift;
    logic [SW:0]        speed_val;
    logic               arrived_new;

    assign pready        = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign cfg_we        = psel && penable && pwrite && pready;
    assign cfg_idx       = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign tgt_in        = s_axis_tdata[PW-1:0];
    assign pos_in        = s_axis_tdata[2*PW-1:PW];

    // register read
    always_comb
    begin
        unique case (cfg_idx)
            REG_MAX_SPEED:  prdata = APB_W'(max_speed_reg);
            REG_MIN_SPEED:  prdata = APB_W'(min_speed_reg);
            REG_ACCEL_DIST: prdata = APB_W'(accel_dist_reg);
            REG_DECEL_DIST: prdata = APB_W'(decel_dist_reg);
            REG_DECEL_GAIN: prdata = APB_W'(decel_gain_reg);
            REG_SEG_LEN:    prdata = APB_W'(seg_len_reg);
            REG_STOP_THR:   prdata = APB_W'(stop_thr_reg);
            default:        prdata = '0;
        endcase
    end

    // step logic of the serial units
    always_comb
    begin
        // prep: phase select and ramp distance
        aerr_x    = XW'(aerr_reg);
        seg_x     = XW'(seg_len_reg);
        dist_a    = seg_x - aerr_x;
        dist_b    = aerr_x - seg_x;
        accel_now = aerr_x > XW'(decel_dist_reg);
        ramp_x    = accel_now ? ((seg_x >= aerr_x) ? dist_a : dist_b) : aerr_x;

        // shift-add multiply, multiplier bits leave at the bottom
        mul_sum = {1'b0, work_reg[NUM_W-1:XW]} + (work_reg[0] ? {1'b0, m2_reg} : '0);

        // restoring divide, dividend bits enter from the top
        div_t  = {drem_reg, work_reg[NUM_W-1]};
        div_ge = div_t >= {1'b0, den_reg};

        // restoring square root, two radicand bits per step
        sq_t     = {srem_reg, work_reg[QE-1:QE-2]};
        sq_trial = (RW+4)'({root_reg, 2'b01});
        sq_ge    = sq_t >= sq_trial;

        // scale: cap root, then ramp or brake magnitude
        root_x = RWX'(root_reg);
        if (cap_reg || (root_x > RWX'({ROOT_W{1'b1}})))
            s32 = '1;
        else
            s32 = root_x[ROOT_W-1:0];
        acc_sum   = {1'b0, s32} + (ROOT_W+1)'(min_speed_reg);
        acc_mag   = (acc_sum > (ROOT_W+1)'(max_speed_reg)) ? max_speed_reg
                                                            : acc_sum[SW-1:0];
        dec_prod  = (ROOT_W+GAIN_W)'(decel_gain_reg) * (ROOT_W+GAIN_W)'(s32);
        dec_shift = dec_prod[ROOT_W+GAIN_W-1:GAIN_W];
        dec_mag   = (|dec_shift[ROOT_W-1:SW]) ? {SW{1'b1}} : dec_shift[SW-1:0];

        // final sign
        arrived_new = arrived_reg || stop_reg;
        if (zero_reg)
            speed_val = '0;
        else if (neg_reg)
            speed_val = '0 - {1'b0, mag_reg};
        else
            speed_val = {1'b0, mag_reg};
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        arrived_next   = arrived_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        aerr_next      = aerr_reg;
        m2_next        = m2_reg;
        accel_next     = accel_reg;
        stop_next      = stop_reg;
        cap_next       = cap_reg;
        den_next       = den_reg;
        work_next      = work_reg;
        drem_next      = drem_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        mag_next       = mag_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    err_next   = EW'($signed({tgt_in[PW-1], tgt_in})
                                     - $signed({pos_in[PW-1], pos_in}));
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                neg_next   = err_reg[EW-1];
                zero_next  = (err_reg == '0);
                aerr_next  = err_reg[EW-1] ? ('0 - err_reg) : err_reg;
                m2_next    = MW'(max_speed_reg) * MW'(max_speed_reg);
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                accel_next = accel_now;
                stop_next  = aerr_reg < EW'(stop_thr_reg);
                den_next   = accel_now ? accel_dist_reg : decel_dist_reg;
                cap_next   = accel_now ? (accel_dist_reg == '0) : (decel_dist_reg == '0);
                work_next  = QE'(ramp_x);
                cnt_next   = CNT_W'(XW - 1);
                if (accel_now ? (accel_dist_reg == '0) : (decel_dist_reg == '0))
                    state_next = ST_SCALE;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                work_next = QE'({mul_sum, work_reg[XW-1:1]});
                if (cnt_reg == '0)
                begin
                    drem_next  = '0;
                    cnt_next   = CNT_W'(NUM_W - 1);
                    state_next = ST_DIV;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_DIV:
            begin
                drem_next = div_ge ? DIST_W'(div_t - {1'b0, den_reg}) : div_t[DIST_W-1:0];
                work_next = QE'({work_reg[NUM_W-2:0], div_ge});
                if (cnt_reg == '0)
                begin
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = CNT_W'(RW - 1);
                    state_next = ST_SQRT;
                end
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_SQRT:
            begin
                srem_next = sq_ge ? (RW+2)'(sq_t - sq_trial) : sq_t[RW+1:0];
                root_next = {root_reg[RW-2:0], sq_ge};
                work_next = {work_reg[QE-3:0], 2'b00};
                if (cnt_reg == '0)
                    state_next = ST_SCALE;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_SCALE:
            begin
                if (stop_reg)
                    mag_next = '0;
                else if (accel_reg)
                    mag_next = acc_mag;
                else
                    mag_next = dec_mag;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = OUT_W'({arrived_new, speed_val});
                    out_valid_next = 1'b1;
                    arrived_next   = arrived_new;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // any mapped register write restarts the arrival latch
        if (cfg_we && (paddr[ADDR_W-1:2] <= REG_STOP_THR))
            arrived_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            arrived_reg    <= 1'b0;
            max_speed_reg  <= SW'(RST_MAX_SPEED);
            min_speed_reg  <= SW'(RST_MIN_SPEED);
            accel_dist_reg <= DIST_W'(RST_ACCEL_DIST);
            decel_dist_reg <= DIST_W'(RST_DECEL_DIST);
            decel_gain_reg <= GAIN_W'(RST_DECEL_GAIN);
            seg_len_reg    <= DIST_W'(RST_SEG_LEN);
            stop_thr_reg   <= STOP_W'(RST_STOP_THR);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            arrived_reg   <= arrived_next;
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_MAX_SPEED:  max_speed_reg  <= pwdata[SW-1:0];
                    REG_MIN_SPEED:  min_speed_reg  <= pwdata[SW-1:0];
                    REG_ACCEL_DIST: accel_dist_reg <= pwdata[DIST_W-1:0];
                    REG_DECEL_DIST: decel_dist_reg <= pwdata[DIST_W-1:0];
                    REG_DECEL_GAIN: decel_gain_reg <= pwdata[GAIN_W-1:0];
                    REG_SEG_LEN:    seg_len_reg    <= pwdata[DIST_W-1:0];
                    REG_STOP_THR:   stop_thr_reg   <= pwdata[STOP_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        aerr_reg     <= aerr_next;
        m2_reg       <= m2_next;
        accel_reg    <= accel_next;
        stop_reg     <= stop_next;
        cap_reg      <= cap_next;
        den_reg      <= den_next;
        work_reg     <= work_next;
        drem_reg     <= drem_next;
        root_reg     <= root_next;
        srem_reg     <= srem_next;
        mag_reg      <= mag_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/srvp_checker.sv =====
// Port-level checks for sqrt_ramp_velocity_profile, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module srvp_checker #(
    parameter int SPEED_WIDTH = 14
) (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   s_axis_tvalid,
    input wire logic                                   s_axis_tready,
    input wire logic                                   m_axis_tvalid,
    input wire logic                                   m_axis_tready,
    input wire logic [((SPEED_WIDTH+2+7)/8)*8-1:0]     m_axis_tdata
);

    localparam int SW = SPEED_WIDTH;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // magnitude is saturated, never the most negative code
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[SW:0] != {1'b1, {SW{1'b0}}}))
        else $error("speed_cmd out of range");

    // one item in flight: input closes after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open after accept");

    // a result never appears the cycle after its item was taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind sqrt_ramp_velocity_profile srvp_checker #(.SPEED_WIDTH(SPEED_WIDTH)) u_srvp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/speed_profile_checker.sv =====
`timescale 1ns / 100ps
// Checker for sqrt_ramp_velocity_profile: watches the stream and APB channels,
// predicts each speed command and arrived flag, and compares. Depends on srvp_pkg.

module speed_profile_checker #(
    parameter int POS_WIDTH   = 20,
    parameter int SPEED_WIDTH = 14
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // tdata: target_pos, robot_pos, zero fill
    input  wire logic [((2*POS_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  wire logic                                 s_axis_tvalid,
    input  wire logic                                 s_axis_tready,
    // tdata: speed_cmd, arrived, zero fill
    input  wire logic [((SPEED_WIDTH+2+7)/8)*8-1:0]   m_axis_tdata,
    input  wire logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [srvp_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [srvp_pkg::APB_W-1:0]           pwdata,
    input  wire logic [srvp_pkg::APB_W-1:0]           prdata,
    input  wire logic                                 pready,
    output int                                        fail_count,
    output int                                        pending,
    output int                                        results_checked
);

    import srvp_pkg::*;

    localparam logic [63:0] SPEED_CAP = (64'd1 << SPEED_WIDTH) - 64'd1;
    localparam int          REPORT_MAX = 30;

    typedef struct packed {
        logic [SPEED_WIDTH:0] speed;
        logic                 arrived;
    } speed_item_t;

    speed_item_t speed_due_q[$];

    // profile registers and arrival latch
    logic [SPEED_WIDTH-1:0] max_speed;
    logic [SPEED_WIDTH-1:0] min_speed;
    logic [DIST_W-1:0]      accel_dist;
    logic [DIST_W-1:0]      decel_dist;
    logic [GAIN_W-1:0]      decel_gain;
    logic [DIST_W-1:0]      seg_len;
    logic [STOP_W-1:0]      stop_thr;
    logic                   arrived_latch;

    int mismatches = 0;
    int checked    = 0;

    // largest root below 2^ROOT_W with root^2 * den <= num_a * num_b
    function automatic logic [63:0] ratio_root(input logic [63:0] num_a,
                                               input logic [63:0] num_b,
                                               input logic [63:0] den);
        logic [127:0] num;
        logic [127:0] trial;
        logic [63:0]  root;
        logic [63:0]  t;
        int           b;
        num  = {64'd0, num_a} * {64'd0, num_b};
        root = '0;
        for (b = ROOT_W - 1; b >= 0; b--)
        begin
            t     = root | (64'd1 << b);
            trial = {64'd0, t * t} * {64'd0, den};
            if (trial <= num)
                root = t;
        end
        return root;
    endfunction

    function automatic speed_item_t step_profile(input logic signed [POS_WIDTH-1:0] tgt,
                                                 input logic signed [POS_WIDTH-1:0] pos);
        longint      err;
        logic [63:0] aerr;
        logic [63:0] span;
        logic [63:0] mag;
        logic [63:0] vmax;
        logic [63:0] vmin;
        speed_item_t res;
        err  = longint'(tgt) - longint'(pos);
        aerr = (err < 0) ? -err : err;
        vmax = 64'(max_speed);
        vmin = 64'(min_speed);
        if (aerr > decel_dist)
        begin
            span = (seg_len >= aerr) ? seg_len - aerr : aerr - seg_len;
            mag  = vmin + ratio_root(vmax * vmax, span, 64'(accel_dist));
            if (mag > vmax)
                mag = vmax;
        end
        else
            mag = (decel_gain * ratio_root(vmax * vmax, aerr, 64'(decel_dist))) >> 8;
        if (mag > SPEED_CAP)
            mag = SPEED_CAP;
        if (aerr < stop_thr)
        begin
            mag           = '0;
            arrived_latch = 1'b1;
        end
        if (err > 0)
            res.speed = mag[SPEED_WIDTH:0];
        else if (err < 0)
            res.speed = '0 - mag[SPEED_WIDTH:0];
        else
            res.speed = '0;
        res.arrived = arrived_latch;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        speed_item_t got;
        speed_item_t want;
        logic        mapped;
        logic [31:0] reg_val;
        if (!rst_n)
        begin
            max_speed     = SPEED_WIDTH'(RST_MAX_SPEED);
            min_speed     = SPEED_WIDTH'(RST_MIN_SPEED);
            accel_dist    = DIST_W'(RST_ACCEL_DIST);
            decel_dist    = DIST_W'(RST_DECEL_DIST);
            decel_gain    = GAIN_W'(RST_DECEL_GAIN);
            seg_len       = DIST_W'(RST_SEG_LEN);
            stop_thr      = STOP_W'(RST_STOP_THR);
            arrived_latch = 1'b0;
            speed_due_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.speed   = m_axis_tdata[SPEED_WIDTH:0];
                got.arrived = m_axis_tdata[SPEED_WIDTH+1];
                if (speed_due_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result, expected none, got speed %0d arrived %0b",
                                 $time, $signed(got.speed), got.arrived);
                end
                else
                begin
                    want = speed_due_q.pop_front();
                    checked++;
                    if (got.speed !== want.speed)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: speed_cmd mismatch, expected %0d, got %0d",
                                     $time, $signed(want.speed), $signed(got.speed));
                    end
                    if (got.arrived !== want.arrived)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: arrived mismatch, expected %0b, got %0b",
                                     $time, want.arrived, got.arrived);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                speed_due_q.push_back(step_profile(s_axis_tdata[POS_WIDTH-1:0],
                                                   s_axis_tdata[2*POS_WIDTH-1:POS_WIDTH]));

            if (psel && penable && pready)
            begin
                mapped  = 1'b1;
                reg_val = '0;
                if (pwrite)
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_MAX_SPEED:  max_speed  = pwdata[SPEED_WIDTH-1:0];
                        REG_MIN_SPEED:  min_speed  = pwdata[SPEED_WIDTH-1:0];
                        REG_ACCEL_DIST: accel_dist = pwdata[DIST_W-1:0];
                        REG_DECEL_DIST: decel_dist = pwdata[DIST_W-1:0];
                        REG_DECEL_GAIN: decel_gain = pwdata[GAIN_W-1:0];
                        REG_SEG_LEN:    seg_len    = pwdata[DIST_W-1:0];
                        REG_STOP_THR:   stop_thr   = pwdata[STOP_W-1:0];
                        default:        mapped     = 1'b0;
                    endcase
                    // any mapped write restarts the move
                    if (mapped)
                        arrived_latch = 1'b0;
                end
                else
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_MAX_SPEED:  reg_val = 32'(max_speed);
                        REG_MIN_SPEED:  reg_val = 32'(min_speed);
                        REG_ACCEL_DIST: reg_val = 32'(accel_dist);
                        REG_DECEL_DIST: reg_val = 32'(decel_dist);
                        REG_DECEL_GAIN: reg_val = 32'(decel_gain);
                        REG_SEG_LEN:    reg_val = 32'(seg_len);
                        REG_STOP_THR:   reg_val = 32'(stop_thr);
                        default:        mapped  = 1'b0;
                    endcase
                    if (mapped && prdata !== reg_val)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: prdata mismatch at 0x%0h, expected %0d, got %0d",
                                     $time, paddr, reg_val, prdata);
                    end
                end
            end
        end
        fail_count      <= mismatches;
        pending         <= speed_due_q.size();
        results_checked <= checked;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sqrt_ramp_velocity_profile testbench: clock, reset, stimulus and verdict.
// Depends on srvp_pkg, the block and speed_profile_checker.

module testbench;

    import srvp_pkg::*;

    localparam int PW = 20;
    localparam int SW = 14;

    localparam int POS_MIN  = -524288;
    localparam int POS_MAX  = 524287;
    localparam int ERR_SPAN = 1048575;

    // word index past the register map; a write there must be ignored
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 250;

    typedef enum logic [1:0] {
        SINK_FREE,      // always ready
        SINK_RANDOM,    // coin flip each cycle
        SINK_SPARSE,    // one cycle in sixteen
        SINK_BUSY       // ready unless sink_cycle[1:0] is zero
    } sink_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    // tdata: target_pos [19:0], robot_pos [39:20]
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: speed_cmd [14:0], arrived [15]
    logic [15:0]           m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_W-1:0]      pwdata;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int results_checked;

    // stimulus bookkeeping; the shadows only steer the error distribution
    int items_sent     = 0;
    int writes_done    = 0;
    int settings_used  = 0;
    int burst_left     = 0;
    int decel_now      = RST_DECEL_DIST;
    int seg_now        = RST_SEG_LEN;
    int stop_now       = RST_STOP_THR;

    sink_mode_t  sink_mode  = SINK_FREE;
    logic [15:0] sink_cycle = '0;

    sqrt_ramp_velocity_profile #(
        .POS_WIDTH   (PW),
        .SPEED_WIDTH (SW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    speed_profile_checker #(
        .POS_WIDTH   (PW),
        .SPEED_WIDTH (SW)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: the stall mode is redrawn whenever sink_cycle[6:0] is zero, so
    // back-pressure meets results that wait in the output register or in ST_FIN.
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 16'd1;
        if (sink_cycle[6:0] == 7'd0)
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            SINK_FREE:   m_axis_tready <= 1'b1;
            SINK_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
            SINK_SPARSE: m_axis_tready <= (sink_cycle[3:0] == 4'd0);
            default:     m_axis_tready <= (sink_cycle[1:0] != 2'd0);
        endcase
    end

    // One item per call; the sender runs in bursts and idles between them.
    // valid stays high across a burst, so it is never dropped and raised in one step.
    task automatic drive_item(input int tgt, input int pos);
        int gap;
        s_axis_tdata  <= {pos[PW-1:0], tgt[PW-1:0]};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Block is idle once every result has been taken: every item yields one.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        writes_done++;
        case (idx)
            REG_DECEL_DIST: decel_now = int'(value[DIST_W-1:0]);
            REG_SEG_LEN:    seg_now   = int'(value[DIST_W-1:0]);
            REG_STOP_THR:   stop_now  = int'(value[STOP_W-1:0]);
            default: ;
        endcase
    endtask

    // the checker compares prdata during the access cycle
    task automatic reg_read(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic [31:0] vmax, input logic [31:0] vmin,
                                 input logic [31:0] adist, input logic [31:0] ddist,
                                 input logic [31:0] gain, input logic [31:0] seglen,
                                 input logic [31:0] stop);
        reg_write(REG_MAX_SPEED, vmax);
        reg_write(REG_MIN_SPEED, vmin);
        reg_write(REG_ACCEL_DIST, adist);
        reg_write(REG_DECEL_DIST, ddist);
        reg_write(REG_DECEL_GAIN, gain);
        reg_write(REG_SEG_LEN, seglen);
        reg_write(REG_STOP_THR, stop);
        reg_read(REG_MAX_SPEED);
        reg_read(REG_MIN_SPEED);
        reg_read(REG_ACCEL_DIST);
        reg_read(REG_DECEL_DIST);
        reg_read(REG_DECEL_GAIN);
        reg_read(REG_SEG_LEN);
        reg_read(REG_STOP_THR);
        settings_used++;
    endtask

    // Field value biased to the ends of its range; now and then junk above
    // the field width, which the block has to drop.
    function automatic logic [31:0] rand_field(input int width, input int low);
        logic [31:0] fmask;
        logic [31:0] v;
        fmask = (32'd1 << width) - 32'd1;
        case ($urandom_range(0, 5))
            0:       v = low;
            1:       v = fmask;
            2:       v = $urandom_range(low, low + 3000);
            default: v = $urandom & fmask;
        endcase
        if (v > fmask)
            v = fmask;
        if (v < low)
            v = low;
        if ($urandom_range(0, 7) == 0)
            v = v | ($urandom & ~fmask);
        return v;
    endfunction

    // Error magnitude aimed at the arrival window, the deceleration region,
    // its edge, the point where |err| equals the segment length, and the
    // acceleration region; a tenth of items use raw random coordinates.
    task automatic random_item();
        int k;
        int aerr;
        int err;
        int lo;
        int hi;
        int pos;
        k = $urandom_range(0, 99);
        if (k < 10)
            drive_item($urandom, $urandom);
        else
        begin
            if (k < 25)
                aerr = $urandom_range(0, stop_now + 2);
            else if (k < 50)
                aerr = $urandom_range(0, decel_now);
            else if (k < 60)
                aerr = decel_now - 2 + $urandom_range(0, 4);
            else if (k < 70)
                aerr = seg_now - 3 + $urandom_range(0, 6);
            else
                aerr = decel_now + 1 + $urandom_range(0, 2 * seg_now + 2000);
            if (aerr < 0)
                aerr = 0;
            if (aerr > ERR_SPAN)
                aerr = ERR_SPAN;
            err = $urandom_range(0, 1) ? -aerr : aerr;
            // pick a position that keeps both coordinates in range
            lo  = (POS_MIN - err > POS_MIN) ? POS_MIN - err : POS_MIN;
            hi  = (POS_MAX - err < POS_MAX) ? POS_MAX - err : POS_MAX;
            pos = lo + int'($urandom_range(0, hi - lo));
            drive_item(pos + err, pos);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset profile: max 9000, min 700, ramps 1000, gain 205, segment 2720,
        // arrival window 20.
        drive_item(500, 0);            // deceleration
        drive_item(-1500, 0);          // acceleration, negative direction
        drive_item(2720, 0);           // |err| equals segment length: min speed only
        drive_item(0, -1000);          // exactly at the deceleration distance
        drive_item(1001, 0);           // one past it
        drive_item(-20, 0);            // at the window edge, not yet arrived
        drive_item(POS_MAX, POS_MIN);  // largest positive error
        drive_item(POS_MIN, POS_MAX);  // largest negative error
        drive_item(19, 0);             // arrives
        drive_item(0, 0);              // zero error
        drive_item(-3000, 0);          // latch holds while far away again
        drain();

        // zero ramp lengths: the root saturates; zero window means no arrival
        apply_setting(9000, 700, 0, 0, 205, 2720, 0);
        drive_item(0, 0);
        drive_item(1, 0);
        drive_item(-100000, 0);
        drain();

        // min above max, full gain, widest deceleration range and window
        apply_setting(100, 16383, 1, 1048575, 255, 1048575, 1023);
        drive_item(POS_MAX, POS_MIN);
        drive_item(1024, 0);
        drive_item(-1023, 0);
        drive_item(-1022, 0);
        drain();

        // full-scale speed, tiny deceleration distance, empty segment
        apply_setting(16383, 0, 1048575, 1, 255, 0, 1);
        drive_item(2, 0);
        drive_item(1, 0);
        drive_item(POS_MIN, POS_MAX);
        drive_item(0, 0);
        drain();

        // write past the map: ignored, arrival latch stays set
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        drive_item(5000, 0);
        drain();

        // everything at zero but the two ramp lengths, which are 1
        apply_setting(0, 0, 1, 1, 0, 0, 0);
        drive_item(-7, 0);
        drive_item(3, 0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_setting(rand_field(SW, 0), rand_field(SW, 0),
                          rand_field(DIST_W, ($urandom_range(0, 9) == 0) ? 0 : 1),
                          rand_field(DIST_W, ($urandom_range(0, 9) == 0) ? 0 : 1),
                          rand_field(GAIN_W, 0), rand_field(DIST_W, 0),
                          rand_field(STOP_W, 0));
            if ($urandom_range(0, 2) == 0)
                reg_write(REG_UNMAPPED, $urandom);
            repeat (ITEMS_PER_PHASE) random_item();
            drain();
        end

        // let any stray result show up before the verdict
        repeat (150) @(posedge clk);
        $display("summary: %0d items driven, %0d results checked, %0d register writes",
                 items_sent, results_checked, writes_done);
        $display("summary: %0d register settings incl. zero ramps, min above max, full scale",
                 settings_used);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
